### rtl/core/naps_pkg.sv
// ----------------------------------------------------------------------------
// naps_pkg
// Shared types, constants and digit functions of the anti-poison sequencer.
// ----------------------------------------------------------------------------
package naps_pkg;

   localparam int DIGIT_W = 4;
   localparam int NUM_DIGITS = 4;
   localparam int WORD_W = 32;
   localparam int HALF_W = 16;

   localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'hF;
   localparam logic [DIGIT_W-1:0] DIGIT_BASE = 4'd10;
   localparam logic [HALF_W-1:0] MASK_A = 16'h01FF;
   localparam logic [HALF_W-1:0] MASK_B = 16'hF007;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [NUM_DIGITS-1:0] digit_set_type;

   typedef struct packed {
      digit_set_type digits;
      logic last;
   } frame_type;

   function automatic digit_type advance(input digit_type v);
      logic [DIGIT_W:0] s;
      s = {1'b0, v} + 1'b1;
      if (s >= {1'b0, DIGIT_BASE}) begin
         s = s - {1'b0, DIGIT_BASE};
      end
      return s[DIGIT_W-1:0];
   endfunction

   function automatic digit_type step_digit(input digit_type cur, input digit_type st,
                                            input digit_type en);
      digit_type v;
      v = advance(cur);
      if (v == en || v == st) begin
         v = advance(v);
      end
      if (v == en || v == st) begin
         v = advance(v);
      end
      return v;
   endfunction

   function automatic logic [WORD_W-1:0] set_reset(input logic [HALF_W-1:0] set,
                                                   input logic [HALF_W-1:0] mask);
      return {~set & mask, set & mask};
   endfunction

endpackage

### rtl/core/naps_frame_engine.sv
// ----------------------------------------------------------------------------
// naps_frame_engine
// Holds the run and steps the digits per frame (a zero start_d0 stays blank).
// ----------------------------------------------------------------------------
module naps_frame_engine
   import naps_pkg::*;
#(
   parameter int FRAME_COUNT = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  digit_set_type start_digits,
   input  digit_set_type end_digits,
   input  logic          advance_en,
   output logic          frame_valid,
   output frame_type     frame
);

   localparam int CNT_W = $clog2(FRAME_COUNT + 1);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_COUNT - 1);

   digit_set_type    st_ff, en_ff, work_ff;
   digit_set_type    st_in, en_in, work_in, next_digits, init_digits;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             active_ff, active_in;
   logic             first_ff, first_in;
   logic             is_last;

   assign is_last = (cnt_ff == LAST_IDX);

   always_comb begin
      for (int j = 0; j < NUM_DIGITS; j++) begin
         next_digits[j] = step_digit(work_ff[j], st_ff[j], en_ff[j]);
      end
      if (first_ff) begin
         next_digits[0] = work_ff[0];
      end
      init_digits = start_digits;
      if (start_digits[0] == '0) begin
         init_digits[0] = BLANK_CODE;
      end
   end

   always_comb begin
      st_in = st_ff;
      en_in = en_ff;
      work_in = work_ff;
      cnt_in = cnt_ff;
      active_in = active_ff;
      first_in = first_ff;
      if (load) begin
         st_in = start_digits;
         en_in = end_digits;
         work_in = init_digits;
         cnt_in = '0;
         active_in = 1'b1;
         first_in = (start_digits[0] == '0);
      end else if (active_ff && advance_en) begin
         work_in = next_digits;
         cnt_in = cnt_ff + 1'b1;
         if (is_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff <= '0;
         work_ff <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff <= cnt_in;
         work_ff <= work_in;
      end
      st_ff <= st_in;
      en_ff <= en_in;
      first_ff <= first_in;
   end

   assign frame_valid = active_ff;
   assign frame.digits = next_digits;
   assign frame.last = is_last;

endmodule

### rtl/core/naps_out_stage.sv
// ----------------------------------------------------------------------------
// naps_out_stage
// Packs one frame into the two port set/reset words and holds the result.
// ----------------------------------------------------------------------------
module naps_out_stage
   import naps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              frame_valid,
   input  frame_type         frame,
   output logic              advance_en,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [2*WORD_W-1:0] rsp_tdata,
   output logic              rsp_tlast
);

   logic [HALF_W-1:0]   set_a, set_b;
   logic [WORD_W-1:0]   word_a_ff, word_b_ff, word_a_in, word_b_in;
   logic                valid_ff, valid_in;
   logic                last_ff, last_in;
   digit_type           d0, d1, d2, d3;

   assign d0 = frame.digits[0];
   assign d1 = frame.digits[1];
   assign d2 = frame.digits[2];
   assign d3 = frame.digits[3];

   assign set_a = {7'b0, d0[3], d2, d3};
   assign set_b = {d0[2:0], d1[3], 9'b0, d1[2:0]};

   assign advance_en = !valid_ff || rsp_tready;

   always_comb begin
      word_a_in = word_a_ff;
      word_b_in = word_b_ff;
      last_in = last_ff;
      valid_in = valid_ff && !rsp_tready;
      if (advance_en && frame_valid) begin
         word_a_in = set_reset(set_a, MASK_A);
         word_b_in = set_reset(set_b, MASK_B);
         last_in = frame.last;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_a_ff <= word_a_in;
      word_b_ff <= word_b_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {word_b_ff, word_a_ff};
   assign rsp_tlast = last_ff;

endmodule

### rtl/core/nixie_anti_poison_sequencer_top.sv
// ----------------------------------------------------------------------------
// nixie_anti_poison_sequencer_top
// Turns one request of old and new tube digits into a run of anti-poison
// frames, each packed into port A and port B set/reset words.
// ----------------------------------------------------------------------------
// Each request yields FRAME_COUNT frames, one per cycle while the result side
// takes them; the next request is accepted in the cycle that produces the last
// frame of the current run, so a new request waits until the current run ends.
// The frames come from the single frame engine. The frame output is registered,
// and the last frame carries tlast.
module nixie_anti_poison_sequencer_top
   import naps_pkg::*;
#(
   parameter int FRAME_COUNT = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // Fields from bit 0: start_d0, start_d1, start_d2, start_d3,
   // end_d0, end_d1, end_d2, end_d3, 4 bits each.
   input  logic [31:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // Fields from bit 0: port_a_word (32 bits), port_b_word (32 bits).
   output logic [2*WORD_W-1:0]  rsp_tdata,
   output logic                 rsp_tlast
);

   digit_set_type start_digits, end_digits;
   frame_type     frame;
   logic          frame_valid;
   logic          advance_en;
   logic          load;

   assign start_digits = req_tdata[15:0];
   assign end_digits = req_tdata[31:16];

   assign req_tready = !frame_valid || (advance_en && frame.last);
   assign load = req_tvalid && req_tready;

   naps_frame_engine #(
      .FRAME_COUNT(FRAME_COUNT)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .load(load),
      .start_digits(start_digits),
      .end_digits(end_digits),
      .advance_en(advance_en),
      .frame_valid(frame_valid),
      .frame(frame)
   );

   naps_out_stage u_out (
      .clock(clock),
      .reset(reset),
      .frame_valid(frame_valid),
      .frame(frame),
      .advance_en(advance_en),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   a_load_starts_run: assert property (@(posedge clock) disable iff (reset)
      load |=> frame_valid)
      else $error("Accepted request did not start a run.");

   a_no_load_mid_run: assert property (@(posedge clock) disable iff (reset)
      (frame_valid && !(advance_en && frame.last)) |-> !req_tready)
      else $error("Request accepted in the middle of a run.");

   a_frame_captured: assert property (@(posedge clock) disable iff (reset)
      (frame_valid && advance_en) |=> rsp_tvalid)
      else $error("Generated frame was not captured in the output register.");

endmodule

### verif/nixie_anti_poison_sequencer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nixie_anti_poison_sequencer_top_tb
// Drives old/new digit requests into the anti-poison sequencer with random
// gaps and result-side stalls. Every request is expanded here into its run of
// frames, and each frame that comes out is compared field by field.
// ----------------------------------------------------------------------------
module nixie_anti_poison_sequencer_top_tb;
   import naps_pkg::*;

   localparam int FRAME_COUNT = 9;
   localparam int NUM_DIRECTED = 20;
   localparam int NUM_ROUNDS = 4;
   localparam int ROUND_ITEMS = 35;

   class frame_board;
      typedef struct {
         logic [WORD_W-1:0] port_a;
         logic [WORD_W-1:0] port_b;
         logic              last;
      } expected_type;

      expected_type frames[$];
      int           errors;

      function new();
         errors = 0;
      endfunction

      function int pending();
         return frames.size();
      endfunction

      function logic [3:0] next_code(input logic [3:0] v);
         return 4'((int'(v) + 1) % 10);
      endfunction

      function logic [WORD_W-1:0] pin_word(input logic [HALF_W-1:0] set,
                                           input logic [HALF_W-1:0] mask);
         return {~set & mask, set & mask};
      endfunction

      function void note_request(input logic [31:0] req);
         logic [3:0]        st[4];
         logic [3:0]        en[4];
         logic [3:0]        cur[4];
         logic [3:0]        v;
         logic [HALF_W-1:0] a;
         logic [HALF_W-1:0] b;
         int                first;
         expected_type      fr;
         for (int j = 0; j < 4; j++) begin
            st[j] = req[4*j +: 4];
            en[j] = req[16 + 4*j +: 4];
            cur[j] = st[j];
         end
         if (st[0] == 4'd0) begin
            cur[0] = BLANK_CODE;
         end
         first = (st[0] != 4'd0) ? 0 : 1;
         for (int f = 0; f < FRAME_COUNT; f++) begin
            for (int j = first; j < 4; j++) begin
               v = next_code(cur[j]);
               if (v == en[j] || v == st[j]) begin
                  v = next_code(v);
               end
               if (v == en[j] || v == st[j]) begin
                  v = next_code(v);
               end
               cur[j] = v;
            end
            a = {7'd0, cur[0][3], cur[2], cur[3]};
            b = {cur[0][2:0], cur[1][3], 9'd0, cur[1][2:0]};
            fr.port_a = pin_word(a, MASK_A);
            fr.port_b = pin_word(b, MASK_B);
            fr.last = (f == FRAME_COUNT - 1);
            frames.push_back(fr);
         end
      endfunction

      function void check_frame(input logic [2*WORD_W-1:0] data, input logic last);
         expected_type fr;
         if (frames.size() == 0) begin
            $error("unexpected frame: port_a_word %h, port_b_word %h, last_frame %b",
                   data[WORD_W-1:0], data[2*WORD_W-1:WORD_W], last);
            errors++;
            return;
         end
         fr = frames.pop_front();
         if (data[WORD_W-1:0] !== fr.port_a) begin
            $error("port_a_word: expected %h, actual %h", fr.port_a, data[WORD_W-1:0]);
            errors++;
         end
         if (data[2*WORD_W-1:WORD_W] !== fr.port_b) begin
            $error("port_b_word: expected %h, actual %h", fr.port_b,
                   data[2*WORD_W-1:WORD_W]);
            errors++;
         end
         if (last !== fr.last) begin
            $error("last_frame: expected %b, actual %b", fr.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [31:0]         req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [2*WORD_W-1:0] rsp_tdata;
   logic                rsp_tlast;

   bit rsp_no_stall = 1'b0;
   bit req_no_gap = 1'b0;

   frame_board board = new();

   // Nibbles from the lowest up: start_d0..start_d3, then end_d0..end_d3.
   logic [31:0] directed_reqs [NUM_DIRECTED] = '{
      32'h0000_0000, 32'h9999_9999, 32'h0000_9999, 32'h9999_0000,
      32'h4321_1234, 32'h5555_5555, 32'h4444_3333, 32'h1234_5670,
      32'h9876_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'hABCD_EFAB,
      32'h8888_8888, 32'h7777_8888, 32'h0000_0001, 32'h1111_0000,
      32'h9012_3456, 32'hFEDC_BA98, 32'h0120_2101, 32'hFFFF_FFFF
   };

   nixie_anti_poison_sequencer_top #(
      .FRAME_COUNT(FRAME_COUNT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_request(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_frame(rsp_tdata, rsp_tlast);
         end
      end
   end

   initial begin
      int hold;
      int roll;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_no_stall) begin
            rsp_tready <= 1'b1;
         end else if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               rsp_tready <= 1'b1;
            end else if (roll < 95) begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(0, 2);
            end else begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(8, 30);
            end
         end
      end
   end

   function automatic logic [31:0] random_request();
      logic [31:0] req;
      int          roll;
      roll = $urandom_range(0, 99);
      for (int j = 0; j < 8; j++) begin
         if (roll < 15) begin
            req[4*j +: 4] = 4'($urandom_range(0, 15));
         end else begin
            req[4*j +: 4] = 4'($urandom_range(0, 9));
         end
      end
      if (roll >= 15 && roll < 30) begin
         req[3:0] = 4'd0;
      end
      return req;
   endfunction

   task automatic request_gap();
      int roll;
      int n;
      roll = $urandom_range(0, 99);
      if (req_no_gap || roll < 60) begin
         return;
      end
      n = (roll < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      req_tvalid <= 1'b0;
      req_tdata <= $urandom;
      repeat (n) @(negedge clock);
   endtask

   task automatic send_request(input logic [31:0] req);
      req_tvalid <= 1'b1;
      req_tdata <= req;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         request_gap();
         send_request(directed_reqs[i]);
      end

      for (int r = 0; r < NUM_ROUNDS; r++) begin
         rsp_no_stall = (r == 1);
         req_no_gap = (r == 1);
         for (int i = 0; i < ROUND_ITEMS; i++) begin
            request_gap();
            send_request(random_request());
         end
         if (r == 1) begin
            // Hold off new requests until the scoreboard has fully drained.
            req_tvalid <= 1'b0;
            while (board.pending() != 0) @(negedge clock);
            @(negedge clock);
         end
      end
      rsp_no_stall = 1'b0;
      req_no_gap = 1'b0;
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(negedge clock);
      repeat (FRAME_COUNT + 10) @(negedge clock);

      if (board.errors == 0) begin
         $display("nixie_anti_poison_sequencer_top test passed");
      end else begin
         $display("nixie_anti_poison_sequencer_top test failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("nixie_anti_poison_sequencer_top test failed");
      $finish;
   end

endmodule
